// ----- sv/bgd_pkg.sv -----
// Package for the button gesture detector: widths, register indexes, result type.
`timescale 1ns / 1ps
`default_nettype none
package bgd_pkg;

  localparam int TIME_BITS    = 17;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 16;
  localparam int COUNT_BITS   = 8;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_BITS-1:0] cfg_dat_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  localparam cfg_idx_t REG_IDLE_LEVEL   = 3'd0;
  localparam cfg_idx_t REG_SHORT_WINDOW = 3'd1;
  localparam cfg_idx_t REG_MULTI_TMO    = 3'd2;
  localparam cfg_idx_t REG_PRESS_TARGET = 3'd3;
  localparam cfg_idx_t REG_HOLD_TIME    = 3'd4;

  localparam logic     RST_IDLE_LEVEL   = 1'b1;
  localparam cfg_dat_t RST_SHORT_WINDOW = 16'd200;
  localparam cfg_dat_t RST_MULTI_TMO    = 16'd500;
  localparam count_t   RST_PRESS_TARGET = 8'd2;
  localparam cfg_dat_t RST_HOLD_TIME    = 16'd1000;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  typedef struct packed {
    logic short_press;
    logic multi_press;
    logic long_hold;
    logic pressed_now;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/button_gesture_detector.sv -----
// Top level of the button gesture detector: press timing, counting and result buffering.
// The result of an accepted sample is registered in the output register, or in the skid entry while that is held.
// Throughput: one sample per cycle while in_stall is low; the elapsed counters and compares update in a single pass.
// A two-entry result buffer (output register plus skid) decouples in_stall from out_stall.
// Reset: rst (synchronous, active high) restores register defaults and clears all
// timing state and the result buffer.
`timescale 1ns / 1ps
`default_nettype none
module button_gesture_detector (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 pin_level,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                short_press,
  output logic                multi_press,
  output logic                long_hold,
  output logic                pressed_now,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire bgd_pkg::cfg_idx_t cfg_index,
  input  wire bgd_pkg::cfg_dat_t cfg_data
);
  import bgd_pkg::*;

  logic     idle_level;
  cfg_dat_t short_window_ms;
  cfg_dat_t multi_timeout_ms;
  count_t   press_target;
  cfg_dat_t hold_time_ms;

  logic   prev_pressed;
  time_t  ms_since_press;
  time_t  ms_since_released;
  count_t short_press_count;
  logic   hold_reported;

  logic   prev_pressed_next;
  time_t  ms_since_press_next;
  time_t  ms_since_released_next;
  count_t short_press_count_next;
  logic   hold_reported_next;

  result_t res_new;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;
  logic    out_free;

  logic   pressed;
  time_t  press_adv;
  time_t  rel_adv;
  count_t count_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level       <= RST_IDLE_LEVEL;
      short_window_ms  <= RST_SHORT_WINDOW;
      multi_timeout_ms <= RST_MULTI_TMO;
      press_target     <= RST_PRESS_TARGET;
      hold_time_ms     <= RST_HOLD_TIME;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IDLE_LEVEL:   idle_level       <= cfg_data[0];
        REG_SHORT_WINDOW: short_window_ms  <= cfg_data;
        REG_MULTI_TMO:    multi_timeout_ms <= cfg_data;
        REG_PRESS_TARGET: press_target     <= cfg_data[COUNT_BITS-1:0];
        REG_HOLD_TIME:    hold_time_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pressed   = pin_level ^ idle_level;
    press_adv = (ms_since_press == TIME_MAX) ? TIME_MAX : ms_since_press + time_t'(1);
    rel_adv   = (ms_since_released == TIME_MAX) ? TIME_MAX
                                                : ms_since_released + time_t'(1);
    count_inc = short_press_count + count_t'(1);

    res_new                = '0;
    res_new.pressed_now    = pressed;
    ms_since_press_next    = press_adv;
    ms_since_released_next = rel_adv;
    short_press_count_next = short_press_count;
    hold_reported_next     = hold_reported;
    prev_pressed_next      = pressed;

    if (!pressed && prev_pressed) begin
      if (press_adv < time_t'(short_window_ms)) begin
        res_new.short_press = 1'b1;
        if (count_inc == press_target) begin
          short_press_count_next = '0;
          res_new.multi_press    = 1'b1;
        end else begin
          short_press_count_next = count_inc;
        end
      end
    end else if (pressed && !prev_pressed) begin
      ms_since_press_next = '0;
    end else if (!pressed) begin
      if (press_adv > time_t'(multi_timeout_ms)) begin
        short_press_count_next = '0;
      end
    end

    if (!pressed) begin
      ms_since_released_next = '0;
      hold_reported_next     = 1'b0;
    end else if (!hold_reported && rel_adv > time_t'(hold_time_ms)) begin
      res_new.long_hold  = 1'b1;
      hold_reported_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pressed      <= 1'b0;
      ms_since_press    <= '0;
      ms_since_released <= '0;
      short_press_count <= '0;
      hold_reported     <= 1'b0;
    end else if (accept) begin
      prev_pressed      <= prev_pressed_next;
      ms_since_press    <= ms_since_press_next;
      ms_since_released <= ms_since_released_next;
      short_press_count <= short_press_count_next;
      hold_reported     <= hold_reported_next;
    end
  end

  // Output register with a skid entry behind it; a new item lands in the skid
  // only while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_new;
      end
    end else if (accept) begin
      skid_res <= res_new;
    end
  end

  assign short_press = out_res.short_press;
  assign multi_press = out_res.multi_press;
  assign long_hold   = out_res.long_hold;
  assign pressed_now = out_res.pressed_now;

endmodule
`default_nettype wire

// ----- sv/bgd_checker.sv -----
// Port-level checker for the button gesture detector and its bind.
`timescale 1ns / 1ps
`default_nettype none
module bgd_checker (
  input wire clk,
  input wire rst,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire short_press,
  input wire multi_press,
  input wire long_hold,
  input wire pressed_now
);

  // a multi-press is always completed by a short press
  assert property (@(posedge clk) disable iff (rst)
    out_valid && multi_press |-> short_press)
    else $error("multi_press without short_press");

  // a short press is a release, so the button reads released
  assert property (@(posedge clk) disable iff (rst)
    out_valid && short_press |-> !pressed_now)
    else $error("short_press while pressed");

  // a hold only fires while pressed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && long_hold |-> pressed_now)
    else $error("long_hold while released");

  // after reset nothing is pending on either side
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall pending after reset");

  // a held result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("held result dropped");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .short_press (short_press),
  .multi_press (multi_press),
  .long_hold   (long_hold),
  .pressed_now (pressed_now)
);
`default_nettype wire
